// ----- src/ddo_pkg.sv -----
// shared types, constants and tables for the differential drive odometry core
// no dependencies
package ddo_pkg;

  localparam int CordicStepsDefault = 24;
  localparam int CordicStepsMax = 32;

  localparam logic signed [35:0] Deg180 = 36'sd754974720;
  localparam logic signed [35:0] Deg90 = 36'sd377487360;
  localparam logic signed [35:0] Deg360 = 36'sd1509949440;
  localparam logic signed [35:0] CordicK = 36'sd652032874;

  typedef enum logic [0:0] {
    OP_INIT   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_ANGLE_L   = 3'd0,
    REG_ANGLE_R   = 3'd1,
    REG_DIST_L    = 3'd2,
    REG_DIST_R    = 3'd3,
    REG_START_X   = 3'd4,
    REG_START_Y   = 3'd5,
    REG_START_HDG = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AR,
    ST_MUL_AL,
    ST_MUL_DR,
    ST_MUL_DL,
    ST_HEAD,
    ST_WRAP,
    ST_REDUCE,
    ST_FOLD,
    ST_CORDIC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE
  } state_t;

  function automatic logic signed [35:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 36'sd188743680;
      5'd1: atan_lut = 36'sd111421900;
      5'd2: atan_lut = 36'sd58872272;
      5'd3: atan_lut = 36'sd29884485;
      5'd4: atan_lut = 36'sd15000234;
      5'd5: atan_lut = 36'sd7507429;
      5'd6: atan_lut = 36'sd3754631;
      5'd7: atan_lut = 36'sd1877430;
      5'd8: atan_lut = 36'sd938729;
      5'd9: atan_lut = 36'sd469366;
      5'd10: atan_lut = 36'sd234683;
      5'd11: atan_lut = 36'sd117342;
      5'd12: atan_lut = 36'sd58671;
      5'd13: atan_lut = 36'sd29335;
      5'd14: atan_lut = 36'sd14668;
      5'd15: atan_lut = 36'sd7334;
      5'd16: atan_lut = 36'sd3667;
      5'd17: atan_lut = 36'sd1833;
      5'd18: atan_lut = 36'sd917;
      5'd19: atan_lut = 36'sd458;
      5'd20: atan_lut = 36'sd229;
      5'd21: atan_lut = 36'sd115;
      5'd22: atan_lut = 36'sd57;
      5'd23: atan_lut = 36'sd29;
      5'd24: atan_lut = 36'sd14;
      5'd25: atan_lut = 36'sd7;
      5'd26: atan_lut = 36'sd4;
      5'd27: atan_lut = 36'sd2;
      5'd28: atan_lut = 36'sd1;
      default: atan_lut = 36'sd0;
    endcase
  endfunction

endpackage

// ----- src/ddo_mul.sv -----
// shared signed multiplier, 33 x 33 bits, product registered
// depends on nothing
module ddo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- src/ddo_cordic.sv -----
// rotation-mode cordic step unit, one micro-rotation per cycle
// depends on ddo_pkg
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [35:0] angle,
  output logic               done,
  output logic signed [35:0] cos_out,
  output logic signed [35:0] sin_out
);
  import ddo_pkg::*;

  localparam int StepW = $clog2(CordicStepsMax + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  logic signed [35:0] x, y, z;
  logic [StepW-1:0] step;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CordicK;
      y <= '0;
      z <= angle;
    end else if (busy) begin
      if (!z[35]) begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - atan_lut(step[4:0]);
      end else begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + atan_lut(step[4:0]);
      end
    end
  end

  assign cos_out = x;
  assign sin_out = y;

  ast_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("cordic done without busy");
  ast_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy || $past(start)) else $error("cordic still busy after done");
  ast_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= LastStep) else $error("cordic step past end");

endmodule

// ----- src/differential_drive_odometry_core.sv -----
// differential drive odometry core: sequencer, state and register file
// depends on ddo_pkg, ddo_mul, ddo_cordic
// init goes straight to done; update runs products, heading, wrap, reduce, fold, cordic, position
// throughput: one item at a time, next accepted once the result is taken
// the single multiplier is shared for all four coefficient products and both position products
// synchronous active-high reset clears all pose state and configuration to zero
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // left_count, right_count
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,  // x_pos, y_pos, heading_out, distance_total, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import ddo_pkg::*;

  state_t state, state_next;

  logic signed [31:0] ang_l, ang_r, dst_l, dst_r, st_hdg;
  logic signed [47:0] st_x, st_y;
  logic [31:0] last_left, last_right;
  logic signed [31:0] heading_now;
  logic signed [47:0] pos_x, pos_y, distance_sum;
  logic signed [32:0] dl, dr;
  logic signed [65:0] acc;
  logic signed [35:0] prev, hnew, zred, zfold;
  logic signed [49:0] step_dist;
  logic fold_neg;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [2:0] phase;
  logic cordic_start, cordic_done;
  logic signed [35:0] cos_v, sin_v;
  logic signed [49:0] dist_hi;
  logic [29:0] dist_lo;
  logic signed [65:0] prod_hi;
  logic signed [35:0] hsum;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_l <= '0; ang_r <= '0; dst_l <= '0; dst_r <= '0;
      st_x <= '0; st_y <= '0; st_hdg <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ANGLE_L:   ang_l <= cfg_data[31:0];
        REG_ANGLE_R:   ang_r <= cfg_data[31:0];
        REG_DIST_L:    dst_l <= cfg_data[31:0];
        REG_DIST_R:    dst_r <= cfg_data[31:0];
        REG_START_X:   st_x <= cfg_data;
        REG_START_Y:   st_y <= cfg_data;
        REG_START_HDG: st_hdg <= {cfg_data[30], cfg_data[30:0]};
        default: ;
      endcase
    end
  end

  ddo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .angle(zfold),
    .done(cordic_done), .cos_out(cos_v), .sin_out(sin_v)
  );

  // distance split for the q30 products: floor part times b plus low part times b
  assign dist_hi = step_dist >>> 30;
  assign dist_lo = step_dist[29:0];
  assign hsum = hnew + prev;
  assign zfold = (zred > Deg90) ? zred - Deg180 :
                 (zred < -Deg90) ? zred + Deg180 : zred;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready)
        state_next = (s_axis_tuser == OP_UPDATE) ? ST_MUL_AR : ST_DONE;
      ST_MUL_AR: state_next = ST_MUL_AL;
      ST_MUL_AL: state_next = ST_MUL_DR;
      ST_MUL_DR: state_next = ST_MUL_DL;
      ST_MUL_DL: state_next = ST_HEAD;
      ST_HEAD:   state_next = ST_WRAP;
      ST_WRAP:   state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_FOLD;
      ST_FOLD:   state_next = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_next = ST_MUL_X;
      ST_MUL_X:  if (phase == 3'd3) state_next = ST_MUL_Y;
      ST_MUL_Y:  if (phase == 3'd3) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_AR: begin mul_a = {ang_r[31], ang_r}; mul_b = dr; end
      ST_MUL_AL: begin mul_a = {ang_l[31], ang_l}; mul_b = dl; end
      ST_MUL_DR: begin mul_a = {dst_r[31], dst_r}; mul_b = dr; end
      ST_MUL_DL: begin mul_a = {dst_l[31], dst_l}; mul_b = dl; end
      ST_MUL_X, ST_MUL_Y: begin
        mul_b = (state == ST_MUL_X) ? cos_v[32:0] : sin_v[32:0];
        // folded angle: the trig value itself is negated
        if (fold_neg) mul_b = -mul_b;
        mul_a = (phase == 3'd0) ? {3'b0, dist_lo} : 33'(dist_hi);
      end
      default: ;
    endcase
  end

  assign cordic_start = (state == ST_FOLD);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      phase <= '0;
      last_left <= '0; last_right <= '0; heading_now <= '0;
      pos_x <= '0; pos_y <= '0; distance_sum <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          last_left <= s_axis_tdata[31:0];
          last_right <= s_axis_tdata[63:32];
          dl <= 33'($signed(s_axis_tdata[31:0] - last_left));
          dr <= 33'($signed(s_axis_tdata[63:32] - last_right));
          if (s_axis_tuser == OP_INIT) begin
            heading_now <= st_hdg;
            pos_x <= st_x;
            pos_y <= st_y;
            distance_sum <= '0;
          end
        end
        ST_MUL_AL: acc <= mul_p;
        ST_MUL_DR: acc <= acc - mul_p;
        ST_MUL_DL: begin
          prev <= 36'(heading_now);
          hnew <= 36'($signed(heading_now + acc[39:8]));
          acc <= mul_p;
        end
        ST_HEAD: begin
          step_dist <= 50'((acc + mul_p) >>> 15);
          if (hnew > Deg180) begin
            hnew <= hnew - Deg360; prev <= prev - Deg360;
          end else if (hnew < -Deg180) begin
            hnew <= hnew + Deg360; prev <= prev + Deg360;
          end
        end
        ST_WRAP: begin
          heading_now <= hnew[31:0];
          distance_sum <= distance_sum + step_dist[47:0];
          // mean heading then reduce into [-180,180)
          zred <= hsum >>> 1;
        end
        ST_REDUCE: begin
          if (zred >= Deg180) zred <= zred - Deg360;
          else if (zred < -Deg180) zred <= zred + Deg360;
        end
        ST_FOLD: begin
          fold_neg <= 1'b0;
          if (zred > Deg90) begin zred <= zred - Deg180; fold_neg <= 1'b1; end
          else if (zred < -Deg90) begin zred <= zred + Deg180; fold_neg <= 1'b1; end
          phase <= '0;
        end
        ST_MUL_X, ST_MUL_Y: begin
          phase <= (phase == 3'd3) ? 3'd0 : phase + 3'd1;
          if (phase == 3'd1) prod_hi <= mul_p >>> 30;
          if (phase == 3'd2) begin
            if (state == ST_MUL_X)
              pos_x <= pos_x + 48'(prod_hi + mul_p);
            else
              pos_y <= pos_y + 48'(prod_hi + mul_p);
          end
        end
        ST_DONE: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, distance_sum, heading_now[30:0], pos_y, pos_x};

  ast_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
  ast_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> m_axis_tvalid) else $error("result not presented");
  ast_wrap_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD |-> zred < Deg180 && zred >= -Deg180) else $error("reduce failed");

endmodule
